### rtl/core/lkxc_pkg.sv
// shared constants, types and helpers for the lcg keystream xor cipher core
`default_nettype none

package lkxc_pkg;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 32;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int KEY_BYTES  = 16;
  localparam int FOLD_IDX_W = $clog2(KEY_BYTES);
  localparam int ROT_AMT    = 5;

  localparam logic [WORD_W-1:0] LCG_A = 32'h71FE_D3C5;
  localparam logic [WORD_W-1:0] LCG_C = 32'h2A9F_1B8D;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE    = 2'd2;

  // byte source for a keystream step
  localparam logic SRC_PORT = 1'b0;
  localparam logic SRC_HELD = 1'b1;

  typedef struct packed {
    logic                  ld_byte;
    logic                  fold_clr;
    logic                  fold_en;
    logic [FOLD_IDX_W-1:0] fold_idx;
    logic                  seed_en;
    logic                  step_en;
    logic                  step_src;
  } lkxc_cmd_t;

  function automatic logic [WORD_W-1:0] rotl5(input logic [WORD_W-1:0] v);
    rotl5 = {v[WORD_W-ROT_AMT-1:0], v[WORD_W-1:WORD_W-ROT_AMT]};
  endfunction

  // low word of a 32x32 product
  function automatic logic [WORD_W-1:0] mul_lo(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b);
    logic [2*WORD_W-1:0] full;
    full   = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
    mul_lo = full[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/lkxc_ctrl.sv
// controller state machine: sequences key fold, seed load and keystream steps
`default_nettype none

module lkxc_ctrl
  import lkxc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  input  wire logic      in_sof,
  output logic           in_tready,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  output lkxc_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FOLD = 2'd1;
  localparam logic [1:0] S_SEED = 2'd2;
  localparam logic [1:0] S_STEP = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [FOLD_IDX_W-1:0] cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;
  logic                  in_acc;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.fold_idx = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_sof) begin
            cmd.ld_byte  = 1'b1;
            cmd.fold_clr = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = S_FOLD;
          end else if (out_free) begin
            cmd.step_en  = 1'b1;
            cmd.step_src = SRC_PORT;
          end else begin
            // result register still full: hold the byte until it drains
            cmd.ld_byte = 1'b1;
            state_nxt   = S_STEP;
          end
        end
      end
      S_FOLD: begin
        cmd.fold_en = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == FOLD_IDX_W'(KEY_BYTES - 1)) begin
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        cmd.seed_en = 1'b1;
        state_nxt   = S_STEP;
      end
      S_STEP: begin
        if (out_free) begin
          cmd.step_en  = 1'b1;
          cmd.step_src = SRC_HELD;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.step_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lkxc_dp.sv
// datapath: config registers, key fold accumulator, lcg state and result register
`default_nettype none

module lkxc_dp
  import lkxc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic [BYTE_W-1:0]    in_byte,
  input  wire lkxc_cmd_t            cmd,
  output logic [BYTE_W-1:0]         out_byte
);

  logic [CFG_W-1:0]  key_low_r, key_high_r, nonce_r;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] lcg_r, lcg_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [BYTE_W-1:0] key_byte;
  logic [BYTE_W-1:0] step_byte;
  logic [2*CFG_W-1:0] key_all;
  logic [WORD_W-1:0] seed;
  logic [WORD_W-1:0] step_val;

  assign key_all  = {key_high_r, key_low_r};
  assign key_byte = key_all[{cmd.fold_idx, 3'b000} +: BYTE_W];
  assign acc_nxt  = rotl5(acc_r) ^ {{(WORD_W-BYTE_W){1'b0}}, key_byte};

  assign seed     = mul_lo(acc_r ^ nonce_r[WORD_W-1:0], LCG_A) + nonce_r[CFG_W-1:WORD_W];
  assign step_val = mul_lo(lcg_r, LCG_A) + LCG_C;

  assign step_byte = (cmd.step_src == SRC_HELD) ? byte_r : in_byte;

  always_comb begin
    lcg_nxt = lcg_r;
    if (cmd.seed_en) begin
      lcg_nxt = seed;
    end else if (cmd.step_en) begin
      lcg_nxt = step_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      nonce_r    <= '0;
      lcg_r      <= '0;
    end else begin
      lcg_r <= lcg_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
          CFG_KEY_HIGH: key_high_r <= cfg_wdata;
          CFG_NONCE:    nonce_r    <= cfg_wdata;
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_byte) begin
      byte_r <= in_byte;
    end
    if (cmd.fold_clr) begin
      acc_r <= '0;
    end else if (cmd.fold_en) begin
      acc_r <= acc_nxt;
    end
    if (cmd.step_en) begin
      out_byte_r <= step_byte ^ step_val[WORD_W-1:WORD_W-BYTE_W];
    end
  end

  assign out_byte = out_byte_r;

endmodule

`default_nettype wire

### rtl/core/lcg_keystream_xor_cipher_core.sv
// top level of the lcg keystream xor byte cipher
//
// input stream: one byte a word in in_tdata, in_tuser marks the first byte
// of a message. output stream: one transformed byte a word in out_tdata.
// cfg port: index 0 key_low, 1 key_high, 2 nonce; other indexes ignored.
// write it only while no message byte is in flight.
// a start-of-message byte folds the 16 key bytes through the accumulator,
// one byte a cycle, then does the seed multiply-add and the keystream step,
// which waits for a free output register; the next byte is taken after it.
// a following byte takes one lcg multiply-add: if the output register is free
// at acceptance its result shows the cycle after, so a message runs at one
// byte per cycle while out_tready stays high.
// the output register holds a result while out_tready is low; one more
// byte is taken and held, then in_tready drops until the result drains.
// reset clears key, nonce and lcg state to zero and empties the output.
`default_nettype none

module lcg_keystream_xor_cipher_core
  import lkxc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [BYTE_W-1:0]    in_tdata,   // [7:0] in_byte
  input  wire logic                 in_tuser,   // [0] start_of_message
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [BYTE_W-1:0]         out_tdata,  // [7:0] out_byte
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  lkxc_cmd_t cmd;

  assign cfg_ready = 1'b1;

  lkxc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_sof     (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  lkxc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .in_byte   (in_tdata),
    .cmd       (cmd),
    .out_byte  (out_tdata)
  );

endmodule

`default_nettype wire

### rtl/core/lkxc_chk.sv
// port-level checker for the cipher core, bound to the top level
`default_nettype none

module lkxc_chk
  import lkxc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic              in_tuser,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [BYTE_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word dropped or changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_cont_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && (!out_tvalid || out_tready) |=> out_tvalid)
    else $error("continuing byte did not produce a result next cycle");

  a_sof_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready ##1 !in_tready)
    else $error("input taken during seed derivation");

endmodule

bind lcg_keystream_xor_cipher_core lkxc_chk u_lkxc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### tb/testbench.sv
// self-checking testbench for the lcg keystream xor cipher core
`timescale 1ns / 1ps

module testbench;
  import lkxc_pkg::*;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int RANDOM_BYTES  = 1150;
  localparam int CALM_BYTES    = 180;
  localparam int SETTLE_CYCLES = 25;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [BYTE_W-1:0]    in_tdata;   // [7:0] in_byte
  logic                 in_tuser;   // [0] start_of_message
  logic                 out_tvalid;
  logic                 out_tready;
  logic [BYTE_W-1:0]    out_tdata;  // [7:0] out_byte
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // predictor copy of the registers and the running generator
  logic [CFG_W-1:0]  key_lo_q;
  logic [CFG_W-1:0]  key_hi_q;
  logic [CFG_W-1:0]  nonce_q;
  logic [WORD_W-1:0] keystream_q;

  logic [BYTE_W-1:0] expected_bytes[$];
  logic [BYTE_W-1:0] want_byte;
  int                err_count = 0;
  int                bytes_sent = 0;
  int                tx_gap_pct = 0;
  int                rx_stall_pct = 0;

  lcg_keystream_xor_cipher_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // key bytes folded through rotate-xor, then nonce mixed in
  function automatic logic [WORD_W-1:0] message_seed();
    logic [WORD_W-1:0]  acc;
    logic [2*CFG_W-1:0] key;
    acc = '0;
    key = {key_hi_q, key_lo_q};
    for (int i = 0; i < KEY_BYTES; i++)
      acc = {acc[26:0], acc[31:27]} ^ {24'd0, key[8*i +: 8]};
    acc = acc ^ nonce_q[WORD_W-1:0];
    acc = acc * LCG_A + nonce_q[CFG_W-1:WORD_W];
    return acc;
  endfunction

  task automatic predict_cipher_byte(input logic [BYTE_W-1:0] b, input logic som);
    if (som) keystream_q = message_seed();
    keystream_q = keystream_q * LCG_A + LCG_C;
    expected_bytes.push_back(b ^ keystream_q[31:24]);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic som);
    if (tx_gap_pct > 0 && $urandom_range(1, 100) <= tx_gap_pct)
      repeat ($urandom_range(1, 18)) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tuser  = som;
    do @(posedge clk); while (!in_tready);
    predict_cipher_byte(b, som);
    bytes_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_KEY_LOW:  key_lo_q = val;
      CFG_KEY_HIGH: key_hi_q = val;
      CFG_NONCE:    nonce_q  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_results_drained();
    while (expected_bytes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_reg_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // all-zero registers, keystream running from a zero state before any start
  task automatic test_zero_config();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b0);
    wait_results_drained();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_KEY_LOW, '1);
    write_reg(CFG_KEY_HIGH, '1);
    write_reg(CFG_NONCE, '1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    wait_results_drained();
    write_reg(CFG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
    write_reg(CFG_KEY_HIGH, 64'hFEDC_BA98_7654_3210);
    write_reg(CFG_NONCE, 64'hFFFF_FFFF_0000_0000);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b0);
    wait_results_drained();
  endtask

  // writes to the spare index must leave the seed alone
  task automatic test_spare_index();
    write_reg(CFG_SPARE, '1);
    write_reg(CFG_NONCE, 64'h0000_0000_FFFF_FFFF);
    send_byte(8'h3C, 1'b1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h7E, 1'b0);
    wait_results_drained();
  endtask

  // new key lands only at the next start; back-to-back starts reseed twice
  task automatic test_config_between_bytes();
    write_reg(CFG_KEY_LOW, 64'h8000_0000_0000_0001);
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    wait_results_drained();
    write_reg(CFG_KEY_LOW, {$urandom, $urandom});
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h66, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    int first;
    int len;
    int kind;
    logic som;
    first = bytes_sent;
    while (bytes_sent - first < RANDOM_BYTES) begin
      if (bytes_sent - first >= RANDOM_BYTES - CALM_BYTES) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: tx_gap_pct = 0;
          1: tx_gap_pct = 5;
          2: tx_gap_pct = 20;
          default: tx_gap_pct = 50;
        endcase
        case ($urandom_range(0, 3))
          0: rx_stall_pct = 0;
          1: rx_stall_pct = 3;
          2: rx_stall_pct = 10;
          default: rx_stall_pct = 30;
        endcase
      end
      if ($urandom_range(0, 3) == 0) begin
        wait_results_drained();
        repeat ($urandom_range(1, 3))
          write_reg(CFG_IDX_W'($urandom_range(0, 3)), pick_reg_value());
      end
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
      // mostly clean messages, some headless runs and some with stray starts
      kind = $urandom_range(0, 9);
      for (int k = 0; k < len; k++) begin
        if (k == 0) som = (kind != 0);
        else som = (kind == 1) && ($urandom_range(0, 4) == 0);
        send_byte(BYTE_W'($urandom_range(0, 255)), som);
      end
    end
  endtask

  // receiver stalls in random bursts
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_stall_pct > 0 && $urandom_range(1, 100) <= rx_stall_pct) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("out_byte: expected none, actual %02h", out_tdata);
        err_count++;
      end else begin
        want_byte = expected_bytes.pop_front();
        if (out_tdata !== want_byte) begin
          $error("out_byte: expected %02h, actual %02h", want_byte, out_tdata);
          err_count++;
        end
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    key_lo_q    = '0;
    key_hi_q    = '0;
    nonce_q     = '0;
    keystream_q = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_zero_config();
    test_register_extremes();
    test_spare_index();
    test_config_between_bytes();
    test_random_traffic();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### lcg_keystream_xor_cipher_core.f
rtl/core/lkxc_pkg.sv
rtl/core/lkxc_ctrl.sv
rtl/core/lkxc_dp.sv
rtl/core/lcg_keystream_xor_cipher_core.sv
rtl/core/lkxc_chk.sv
tb/testbench.sv
